// ----- rtl/gftb_pkg.sv -----
`default_nettype none
package gftb_pkg;

  // Sizing of the table store
  localparam int WORD_BITS  = 64;  // kept bits of each row word
  localparam int TABLE_BITS = 8;   // rows per table; entries = 2^TABLE_BITS
  localparam int NUM_TABLES = 8;

  localparam int ENTRIES     = 1 << TABLE_BITS;
  localparam int STORE_DEPTH = NUM_TABLES * ENTRIES;
  localparam int TSEL_W      = $clog2(NUM_TABLES);
  localparam int ROWS_W      = $clog2(TABLE_BITS + 1);

  typedef logic [ROWS_W-1:0] rows_t;

  // Operation codes
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/gf2_four_russians_table_builder.sv -----
`default_nettype none
// Four Russians table builder for GF(2) multiply.
// Request channel (req_valid/req_stall) carries func, table_select,
// row_word and entry_index; response channel (rsp_valid/rsp_stall)
// returns read_data, status and rows_loaded, one response per request.
// Load row n of a table: writes entries 2^n .. 2^(n+1)-1 as lower half
// XOR row, through one XOR unit and the single-port-pair table RAM, one
// entry a cycle. A load sweeps the lower half in S_LOAD and answers from
// S_TAIL, where the last write goes out. A read of a stored entry passes
// through the registered RAM read and S_READ before it answers; entry 0,
// refused loads, bad reads, clears and unused codes are answered from
// S_IDLE as they are accepted. One request is in hand at a time.
// Entry 0 of every table is zero by definition and is never stored.
// Reset clears the per-table row counts, so every table is empty; the
// RAM is not cleared and needs no sweep. A stalled response is held in
// the output registers; req_stall stays high until it can be replaced.
module gf2_four_russians_table_builder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  func,
  input  wire logic [2:0]  table_select,
  input  wire logic [63:0] row_word,
  input  wire logic [7:0]  entry_index,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [63:0]      read_data,
  output logic [1:0]       status,
  output logic [3:0]       rows_loaded
);

  import gftb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_TAIL, S_READ} state_t;

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  state_t                 state;
  rows_t                  row_counts [NUM_TABLES];
  logic [TSEL_W-1:0]      sel_q;
  logic [WORD_BITS-1:0]   row_q;
  logic [TABLE_BITS-1:0]  half_q;   // 2^n for the row being appended
  logic [TABLE_BITS-1:0]  k_q;      // source entry being read
  logic [TABLE_BITS-1:0]  k_d;      // source entry whose data is on rd_data
  logic                   wr_pend;

  logic                   accept;
  logic                   sel_ok;
  logic [TSEL_W-1:0]      sel_i;
  rows_t                  n_sel;
  logic                   idx_ok;

  logic                   ram_wr_en;
  logic [ADDR_W-1:0]      ram_wr_addr;
  logic [WORD_BITS-1:0]   ram_wr_data;
  logic                   ram_rd_en;
  logic [ADDR_W-1:0]      ram_rd_addr;
  logic [WORD_BITS-1:0]   ram_rd_data;

  // Only one request in hand; the response register must be free or
  // emptying when a new one is taken.
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  assign sel_ok = 32'(table_select) < NUM_TABLES;
  assign sel_i  = table_select[TSEL_W-1:0];
  assign n_sel  = row_counts[sel_i];
  assign idx_ok = ((entry_index >> n_sel) == 8'd0) && (32'(entry_index) < ENTRIES);

  // Read side: request address when idle, sweep counter while loading.
  assign ram_rd_addr = (state == S_IDLE) ? {sel_i, TABLE_BITS'(entry_index)}
                                         : {sel_q, k_q};
  assign ram_rd_en   = (state == S_LOAD) ||
                       (accept && (func == FN_READ) && sel_ok && idx_ok &&
                        (entry_index != 8'd0));

  // Write side: each write goes out in the cycle after its read. Entry 0
  // is never stored, so its data is forced to zero here.
  assign ram_wr_en   = wr_pend;
  assign ram_wr_addr = {sel_q, half_q | k_d};
  assign ram_wr_data = ((k_d == '0) ? '0 : ram_rd_data) ^ row_q;

  gftb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      wr_pend    <= 1'b0;
      row_counts <= '{default: '0};
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sel_q       <= sel_i;
            row_q       <= row_word[WORD_BITS-1:0];
            k_q         <= '0;
            half_q      <= TABLE_BITS'(1) << n_sel;
            read_data   <= '0;
            status      <= ST_OK;
            rows_loaded <= sel_ok ? 4'(n_sel) : 4'd0;
            unique case (func)
              FN_LOAD: begin
                if (!sel_ok || (32'(n_sel) >= TABLE_BITS)) begin
                  status    <= ST_FULL;
                  rsp_valid <= 1'b1;
                end else begin
                  state <= S_LOAD;
                end
              end
              FN_READ: begin
                if (!sel_ok || !idx_ok) begin
                  status    <= ST_RANGE;
                  rsp_valid <= 1'b1;
                end else if (entry_index == 8'd0) begin
                  rsp_valid <= 1'b1;  // empty subset, always zero
                end else begin
                  state <= S_READ;
                end
              end
              FN_CLEAR: begin
                if (sel_ok) begin
                  row_counts[sel_i] <= '0;
                end
                rows_loaded <= 4'd0;
                rsp_valid   <= 1'b1;
              end
              default: begin
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end
        S_LOAD: begin
          k_d     <= k_q;
          wr_pend <= 1'b1;
          if (k_q == half_q - 1'b1) begin
            state <= S_TAIL;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_TAIL: begin
          // last write of the sweep goes out this cycle
          wr_pend            <= 1'b0;
          row_counts[sel_q]  <= row_counts[sel_q] + 1'b1;
          rows_loaded        <= 4'(row_counts[sel_q] + 1'b1);
          rsp_valid          <= 1'b1;
          state              <= S_IDLE;
        end
        S_READ: begin
          read_data   <= 64'(ram_rd_data);
          rows_loaded <= 4'(row_counts[sel_q]);
          rsp_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gftb_ram.sv -----
`default_nettype none
module gftb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
// Self-checking bench for the four Russians table builder.
// A queue of pending requests, filled at time zero, feeds a clocked driver;
// the driver predicts each accepted request against its own copy of the
// tables and a clocked monitor checks every response against the oldest
// prediction.
module testbench;
  import gftb_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RANDOM_REQUESTS = 1800;
  localparam int DRAIN_CYCLES = 200;       // longer than the longest load takes to answer
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_AFTER = 300;      // responses seen before the long hold-off
  localparam logic [1:0] FN_UNUSED = 2'd3; // spare code, must be a no-op

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  tsel;
    logic [63:0] row;
    logic [7:0]  idx;
  } req_item_t;

  typedef struct {
    logic [63:0] data;
    logic [1:0]  st;
    rows_t       rows;
  } rsp_t;

  // DUT ports; every input known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  func = FN_LOAD;
  logic [2:0]  table_select = '0;
  logic [63:0] row_word = '0;
  logic [7:0]  entry_index = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [63:0] read_data;
  logic [1:0]  status;
  logic [3:0]  rows_loaded;

  gf2_four_russians_table_builder dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .table_select (table_select),
    .row_word     (row_word),
    .entry_index  (entry_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .read_data    (read_data),
    .status       (status),
    .rows_loaded  (rows_loaded)
  );

  // Requests waiting to be offered, and responses owed by the block
  req_item_t pending_reqs[$];
  rsp_t      owed_rsps[$];

  // Bench copy of the tables: entry g of a table is the XOR of the rows
  // whose bits are set in g. Entry 0 is held at zero.
  logic [WORD_BITS-1:0] model_tables [NUM_TABLES][ENTRIES];
  int unsigned          model_rows [NUM_TABLES];

  // Row counts as seen by the request generator, so reads can be aimed
  // mostly inside the built part of a table
  int unsigned gen_rows [NUM_TABLES];

  int unsigned requests_queued = 0;
  int unsigned requests_accepted = 0;
  int unsigned responses_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_no = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  // What the run went through, tallied as requests are accepted
  int unsigned n_rows_added = 0, n_full = 0, n_reads_ok = 0, n_range = 0;
  int unsigned n_clears = 0, n_unused = 0, n_tables_filled = 0;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // Neither side idles at random inside this window of cycles
  function automatic bit quiet_window();
    return cycle_no >= 3000 && cycle_no < 7000;
  endfunction

  function automatic logic [63:0] random_row();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      2:       return 64'h1 << $urandom_range(0, 63);
      3:       return ~(64'h1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void queue_request(logic [1:0] op, logic [2:0] tsel,
                                        logic [63:0] row, logic [7:0] idx);
    req_item_t r;
    r.op = op;
    r.tsel = tsel;
    r.row = row;
    r.idx = idx;
    pending_reqs.push_back(r);
    requests_queued++;
    if (op == FN_LOAD && gen_rows[tsel] < TABLE_BITS) gen_rows[tsel]++;
    if (op == FN_CLEAR) gen_rows[tsel] = 0;
  endfunction

  // Applies one accepted request to the bench tables and records the
  // response the block owes for it.
  task automatic predict_response(input logic [1:0] op, input logic [2:0] tsel,
                                  input logic [63:0] row, input logic [7:0] idx);
    rsp_t        r;
    int unsigned n;
    int unsigned half;
    r.data = '0;
    r.st = ST_OK;
    r.rows = '0;
    if (int'(tsel) >= NUM_TABLES) begin
      // no such table: state untouched, zero rows reported
      if (op == FN_LOAD) r.st = ST_FULL;
      else if (op == FN_READ) r.st = ST_RANGE;
    end else begin
      n = model_rows[tsel];
      case (op)
        FN_LOAD: begin
          if (n >= TABLE_BITS) begin
            r.st = ST_FULL;
            n_full++;
          end else begin
            // new upper half = lower half XOR the row
            half = 1 << n;
            for (int k = 0; k < half; k++)
              model_tables[tsel][half + k] = model_tables[tsel][k] ^ row[WORD_BITS-1:0];
            model_rows[tsel] = n + 1;
            n_rows_added++;
            if (n + 1 == TABLE_BITS) n_tables_filled++;
          end
        end
        FN_READ: begin
          if (idx < (1 << n)) begin
            r.data = 64'(model_tables[tsel][idx]);
            n_reads_ok++;
          end else begin
            r.st = ST_RANGE;
            n_range++;
          end
        end
        FN_CLEAR: begin
          model_rows[tsel] = 0;
          model_tables[tsel][0] = '0;
          n_clears++;
        end
        default: n_unused++;
      endcase
      r.rows = rows_t'(model_rows[tsel]);
    end
    owed_rsps.push_back(r);
  endtask

  // Request driver: the payload holds while stalled; a new request, or
  // an idle cycle, is chosen only once the current one has gone.
  always @(posedge clk) begin : drive_requests
    req_item_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_response(func, table_select, row_word, entry_index);
        requests_accepted++;
      end
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && (quiet_window() || $urandom_range(0, 99) >= 25)) begin
          nxt = pending_reqs.pop_front();
          req_valid <= 1'b1;
          func <= nxt.op;
          table_select <= nxt.tsel;
          row_word <= nxt.row;
          entry_index <= nxt.idx;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off on the response side, so the block fills up and has
  // to stall incoming requests while the driver keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && responses_seen >= HOLDOFF_AFTER) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end
  end

  // Response monitor: every accepted response must match the oldest
  // prediction, field by field.
  always @(posedge clk) begin : check_responses
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        responses_seen++;
        if (owed_rsps.size() == 0) begin
          $display("%0t: response with no request outstanding: data %h status %0d rows %0d",
                   $time, read_data, status, rows_loaded);
          fail_count++;
        end else begin
          want = owed_rsps.pop_front();
          if (read_data !== want.data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.data, read_data);
            fail_count++;
          end
          if (status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            fail_count++;
          end
          if (rows_loaded !== want.rows) begin
            $display("%0t: rows_loaded expected %0d actual %0d", $time, want.rows, rows_loaded);
            fail_count++;
          end
        end
      end
      rsp_stall <= (holdoff_left != 0) || (!quiet_window() && $urandom_range(0, 99) < 25);
    end
  end

  initial begin
    int unsigned pick, t, n;

    for (int i = 0; i < NUM_TABLES; i++) begin
      model_rows[i] = 0;
      model_tables[i][0] = '0;
      gen_rows[i] = 0;
    end

    // Directed: empty table reads, a short table, one table filled to the
    // brim and refused, a clear, and the spare code.
    queue_request(FN_READ, 3'd0, '0, 8'd0);          // entry 0 of an empty table
    queue_request(FN_READ, 3'd0, '1, 8'd1);          // just past the built part
    queue_request(FN_LOAD, 3'd0, '1, 8'd0);
    queue_request(FN_LOAD, 3'd0, '0, 8'hFF);
    queue_request(FN_LOAD, 3'd0, 64'h8000_0000_0000_0001, 8'd0);
    queue_request(FN_READ, 3'd0, '0, 8'd7);
    queue_request(FN_READ, 3'd0, '0, 8'd5);
    queue_request(FN_READ, 3'd0, '0, 8'd8);          // first index beyond
    queue_request(FN_READ, 3'd0, '0, 8'd255);
    for (int k = 0; k < TABLE_BITS; k++)
      queue_request(FN_LOAD, 3'd7, (64'h0123_4567_89AB_CDEF << k) ^ {$urandom, $urandom}, 8'd0);
    queue_request(FN_LOAD, 3'd7, '1, 8'd0);          // table full
    queue_request(FN_READ, 3'd7, '0, 8'd255);        // last entry of a full table
    queue_request(FN_CLEAR, 3'd7, '1, 8'd255);
    queue_request(FN_READ, 3'd7, '0, 8'd0);
    queue_request(FN_READ, 3'd7, '0, 8'd1);
    queue_request(FN_UNUSED, 3'd0, '1, 8'hFF);

    // Random: mostly loads and reads aimed into the built part, with
    // occasional clears so tables cycle between empty, partial and full.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 99);
      t = $urandom_range(0, 7);
      n = gen_rows[t];
      if (pick < 40)
        queue_request(FN_LOAD, 3'(t), random_row(), 8'($urandom));
      else if (pick < 82)
        queue_request(FN_READ, 3'(t), {$urandom, $urandom},
                      ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, (1 << n) - 1))
                                                 : 8'($urandom));
      else if (pick < 90)
        queue_request(FN_CLEAR, 3'(t), {$urandom, $urandom}, 8'($urandom));
      else
        queue_request(FN_UNUSED, 3'(t), {$urandom, $urandom}, 8'($urandom));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (requests_accepted != requests_queued) @(posedge clk);
    while (owed_rsps.size() != 0) @(posedge clk);
    // a stray extra response would show up here
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d rows appended, %0d tables filled, %0d loads refused",
             requests_accepted, n_rows_added, n_tables_filled, n_full);
    $display("  %0d reads in range, %0d out of range, %0d clears, %0d spare-code requests",
             n_reads_ok, n_range, n_clears, n_unused);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #(CLK_PERIOD * 2_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/gftb_pkg.sv
rtl/gftb_ram.sv
rtl/gf2_four_russians_table_builder.sv
tb/sv/testbench.sv
